[hw/rtl/word_mask_filter_unit_assert.svh]
// Assertion macros used by the word mask filter window engine.
// Expects clk and rst_n in the scope of each use.
`ifndef WORD_MASK_FILTER_UNIT_ASSERT_SVH
`define WORD_MASK_FILTER_UNIT_ASSERT_SVH

// Property that holds at every clock edge out of reset
`define WMF_ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define WMF_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define WMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/wmf_pkg.sv]
// Shared types, constants and character helpers of the word mask filter.
// No dependencies.
package wmf_pkg;

    localparam int CHAR_W              = 8;
    localparam int LEN_W               = 5;
    localparam int CFG_DATA_W          = 64;
    localparam int CFG_IDX_W           = 2;
    localparam int PATTERN_BYTES       = 16;
    localparam int MAX_PATTERN_DEFAULT = 16;
    localparam int FIFO_DEPTH          = 4;
    localparam int QPTR_W              = $clog2(FIFO_DEPTH);
    localparam int QCNT_W              = $clog2(FIFO_DEPTH + 1);

    localparam logic [CHAR_W-1:0] ASTERISK    = 8'h2A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;
    localparam logic [CHAR_W-1:0] UPPER_A     = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_Z     = 8'h5A;
    localparam logic [CHAR_W-1:0] LOWER_A     = 8'h61;
    localparam logic [CHAR_W-1:0] LOWER_Z     = 8'h7A;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 2'd0,
        REG_PATTERN_LOW    = 2'd1,
        REG_PATTERN_HIGH   = 2'd2,
        REG_WORD_MODE      = 2'd3
    } cfg_reg_t;

    // One classified text item as it sits in the queue
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              is_letter;
        logic              last;
    } wmf_item_t;

    typedef struct packed {
        logic                            full;
        logic                            empty;
    } wmf_q_stat_t;

    typedef struct packed {
        logic [LEN_W-1:0]                pattern_length;
        logic [PATTERN_BYTES*CHAR_W-1:0] pattern;
        logic                            word_mode;
    } wmf_cfg_t;

    function automatic logic char_is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= LOWER_A) && (c <= LOWER_Z)) || ((c >= UPPER_A) && (c <= UPPER_Z));
    endfunction

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        return ((c >= UPPER_A) && (c <= UPPER_Z)) ? c + CASE_OFFSET : c;
    endfunction

endpackage

[hw/rtl/wmf_if.sv]
// Valid/ready stream interfaces for text going into and out of the filter.
// No dependencies.
interface wmf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last_in;

    modport source (output valid, output char_in, output last_in, input ready);
    modport sink   (input valid, input char_in, input last_in, output ready);
endinterface

interface wmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last_out;

    modport source (output valid, output char_out, output last_out, input ready);
    modport sink   (input valid, input char_out, input last_out, output ready);
endinterface

[hw/rtl/wmf_front.sv]
// Front end: takes text items, folds case, tags letters and pushes them to the queue.
// Depends on wmf_pkg and wmf_in_if.
module wmf_front import wmf_pkg::*;
(
    wmf_in_if.sink      text,
    input  wmf_q_stat_t q_stat,
    output logic        push,
    output wmf_item_t   push_item
);

    logic [CHAR_W-1:0] folded;

    assign folded     = fold_case(text.char_in);
    assign text.ready = !q_stat.full;
    assign push       = text.valid && !q_stat.full;

    always_comb
    begin
        push_item.ch        = folded;
        push_item.is_letter = char_is_letter(folded);
        push_item.last      = text.last_in;
    end

endmodule

[hw/rtl/wmf_queue.sv]
// Short item queue between the front end and the window engine.
// Depends on wmf_pkg.
module wmf_queue import wmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  wmf_item_t   push_item,
    input  logic        pop,
    output wmf_item_t   head,
    output wmf_q_stat_t q_stat
);

    wmf_item_t          slot_reg [FIFO_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign head         = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == QCNT_W'(FIFO_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hw/rtl/wmf_back.sv]
// Window engine: holds the pattern window, compares, masks and emits items.
// Depends on wmf_pkg, wmf_out_if and the assertion macros.
`include "word_mask_filter_unit_assert.svh"

module wmf_back import wmf_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  wmf_cfg_t    cfg,
    input  wmf_item_t   head,
    input  wmf_q_stat_t q_stat,
    output logic        pop,
    wmf_out_if.source   masked
);

    localparam int WinDepth = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;
    localparam int FillW    = $clog2(WinDepth + 1);
    localparam int IdxW     = (WinDepth > 1) ? $clog2(WinDepth) : 1;

    logic [CHAR_W-1:0] win_reg  [WinDepth];
    logic [CHAR_W-1:0] win_next [WinDepth];
    logic [CHAR_W-1:0] win_up   [WinDepth];
    logic [FillW-1:0]  fill_reg, fill_next;
    logic              prior_reg, prior_next;
    logic              flush_reg, flush_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    logic [FillW-1:0]  act_len;
    logic [WinDepth-1:0] win_eq;
    logic              head_valid;
    logic              can_emit;
    logic              next_letter;
    logic              window_full;
    logic              match;
    logic              emit;
    logic [CHAR_W-1:0] emit_char;
    logic              emit_last;
    logic              do_shift;
    logic              do_append;
    logic              use_mask;
    logic [IdxW-1:0]   wr_idx;
    logic [FillW-1:0]  len_minus_one;

    // Saturate the configured length to what the window can hold
    assign act_len = (cfg.pattern_length > LEN_W'(WinDepth)) ?
                     FillW'(WinDepth) : FillW'(cfg.pattern_length);
    assign len_minus_one = act_len - FillW'(1);

    assign head_valid  = !q_stat.empty;
    assign can_emit    = !out_valid_reg || masked.ready;
    assign next_letter = flush_reg ? 1'b0 : head.is_letter;
    assign window_full = (act_len != '0) && (fill_reg == act_len);

    always_comb
    begin
        for (int k = 0; k < WinDepth; k++)
        begin
            win_eq[k] = (FillW'(k) >= act_len) ||
                        (win_reg[k] == cfg.pattern[CHAR_W*k +: CHAR_W]);
        end
    end

    assign match = window_full && (&win_eq) &&
                   !(cfg.word_mode && (next_letter || prior_reg));

    // Shifted view of the window, oldest byte dropped
    for (genvar g = 0; g < WinDepth; g++)
    begin : g_up
        if (g < WinDepth - 1)
        begin : g_mid
            assign win_up[g] = win_reg[g+1];
        end
        else
        begin : g_top
            assign win_up[g] = win_reg[g];
        end
    end

    always_comb
    begin
        fill_next  = fill_reg;
        prior_next = prior_reg;
        flush_next = flush_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        emit_char  = win_reg[0];
        emit_last  = 1'b0;
        do_shift   = 1'b0;
        do_append  = 1'b0;
        use_mask   = 1'b0;
        wr_idx     = fill_reg[IdxW-1:0];

        if (flush_reg)
        begin
            // Drain the window after the final item
            if (can_emit)
            begin
                emit      = 1'b1;
                use_mask  = 1'b1;
                do_shift  = 1'b1;
                emit_last = (fill_reg == FillW'(1));
                fill_next = fill_reg - FillW'(1);
            end
        end
        else if (head_valid)
        begin
            if (fill_reg > act_len)
            begin
                // Length was lowered: drop excess bytes out unmasked first
                if (can_emit)
                begin
                    emit      = 1'b1;
                    do_shift  = 1'b1;
                    fill_next = fill_reg - FillW'(1);
                end
            end
            else if (act_len == '0)
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_char = head.ch;
                    emit_last = head.last;
                    pop       = 1'b1;
                end
            end
            else if (fill_reg == act_len)
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    use_mask   = 1'b1;
                    do_shift   = 1'b1;
                    do_append  = 1'b1;
                    wr_idx     = len_minus_one[IdxW-1:0];
                    pop        = 1'b1;
                    flush_next = head.last;
                end
            end
            else
            begin
                do_append  = 1'b1;
                fill_next  = fill_reg + FillW'(1);
                pop        = 1'b1;
                flush_next = head.last;
            end
        end

        if (use_mask && match)
        begin
            emit_char = ASTERISK;
        end

        if (emit)
        begin
            if (act_len == '0 && !flush_reg && !(fill_reg > act_len))
            begin
                prior_next = head.last ? 1'b0 : head.is_letter;
            end
            else
            begin
                prior_next = char_is_letter(emit_char);
            end
        end

        // Final byte of the flush closes the text
        if (flush_reg && emit && emit_last)
        begin
            flush_next = 1'b0;
            prior_next = 1'b0;
        end
    end

    always_comb
    begin
        for (int k = 0; k < WinDepth; k++)
        begin
            if (do_append && (IdxW'(k) == wr_idx))
            begin
                win_next[k] = head.ch;
            end
            else if (do_shift && use_mask && match)
            begin
                win_next[k] = ASTERISK;
            end
            else if (do_shift)
            begin
                win_next[k] = win_up[k];
            end
            else
            begin
                win_next[k] = win_reg[k];
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_char;
            out_last_next  = emit_last;
        end
        else if (masked.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            prior_reg     <= 1'b0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            prior_reg     <= prior_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg      <= win_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign masked.valid    = out_valid_reg;
    assign masked.char_out = out_char_reg;
    assign masked.last_out = out_last_reg;

    `WMF_ASSERT_HOLDS(a_fill_bound, fill_reg <= FillW'(WinDepth), "window fill beyond depth")
    `WMF_ASSERT_IMPLIES(a_flush_nonempty, flush_reg, fill_reg != '0, "flush on empty window")
    `WMF_ASSERT_IMPLIES(a_no_pop_in_flush, flush_reg, !pop, "item taken during flush")
    `WMF_ASSERT_NEXT(a_flush_end, flush_reg && emit && emit_last, !flush_reg && !prior_reg, "flush did not close text")

endmodule

[hw/rtl/word_mask_filter_unit.sv]
// Word mask filter top level: configuration registers, front end, queue, window engine.
// A result is registered and presented in the cycle after the item that releases it is taken.
// Throughput: one item per cycle while the receiver is ready; a final item then drains the window at one item per
// cycle with input held, and a lowered length drains the excess likewise.
// Reset clears control state and the pattern registers and sets word mode; window contents stay undefined, no sweep.
module word_mask_filter_unit import wmf_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    wmf_in_if.sink                text,
    wmf_out_if.source             masked,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [LEN_W-1:0]      pattern_length_reg;
    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic                  word_mode_reg;

    wmf_cfg_t    cfg;
    wmf_q_stat_t q_stat;
    wmf_item_t   push_item;
    wmf_item_t   head;
    logic        push;
    logic        pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            word_mode_reg      <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                REG_WORD_MODE:      word_mode_reg      <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        cfg.pattern_length = pattern_length_reg;
        cfg.pattern        = {pattern_high_reg, pattern_low_reg};
        cfg.word_mode      = word_mode_reg;
    end

    wmf_front u_front (
        .text      (text),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    wmf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    wmf_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .masked (masked)
    );

endmodule

[verif/word_mask_filter_unit_tb.sv]
// Self-checking testbench for word_mask_filter_unit: text streams in, masked text is checked.
// Depends on wmf_pkg and the wmf_in_if / wmf_out_if interfaces from the RTL.
module word_mask_filter_unit_tb import wmf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WINDOW    = MAX_PATTERN_DEFAULT;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 60;
    localparam int TARGET_ITEMS  = 270;

    localparam logic [CHAR_W-1:0] SEPARATORS [10] = '{
        8'h20, 8'h2C, 8'h2E, 8'h2D, 8'h0A, ASTERISK, 8'h40, 8'h5B, 8'h60, 8'h7B
    };

    typedef logic [CHAR_W-1:0] byte_q_t [$];

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_EVERY_FOURTH,
        RX_MOSTLY
    } rx_pattern_t;

    // Tracks window, boundary and registers; holds the masked text still to come.
    class mask_tracker;
        typedef struct {
            logic [CHAR_W-1:0] ch;
            logic              last;
        } masked_char_t;

        logic [LEN_W-1:0]      length_reg;
        logic [63:0]           pat_low;
        logic [63:0]           pat_high;
        logic                  word_reg;
        logic [CHAR_W-1:0]     window [MAX_WINDOW];
        int                    fill;
        bit                    prior_letter;
        masked_char_t          expected_masked [$];
        int                    errors;

        function new();
            length_reg   = '0;
            pat_low      = '0;
            pat_high     = '0;
            word_reg     = 1'b1;
            fill         = 0;
            prior_letter = 1'b0;
            errors       = 0;
            foreach (window[k])
                window[k] = '0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PATTERN_LENGTH: length_reg = data[LEN_W-1:0];
                REG_PATTERN_LOW:    pat_low    = data;
                REG_PATTERN_HIGH:   pat_high   = data;
                REG_WORD_MODE:      word_reg   = data[0];
                default: ;
            endcase
        endfunction

        function bit is_letter(logic [CHAR_W-1:0] b);
            return (b >= LOWER_A && b <= LOWER_Z) || (b >= UPPER_A && b <= UPPER_Z);
        endfunction

        function int active_len();
            int len;
            len = int'(length_reg);
            if (len > MAX_WINDOW)
                len = MAX_WINDOW;
            if (len > PATTERN_BYTES)
                len = PATTERN_BYTES;
            return len;
        endfunction

        function logic [CHAR_W-1:0] pattern_byte(int k);
            if (k < 8)
                return pat_low[8*k +: 8];
            return pat_high[8*(k-8) +: 8];
        endfunction

        function void try_mask(int len, bit next_letter);
            if (len == 0 || fill != len)
                return;
            for (int k = 0; k < len; k++)
                if (window[k] != pattern_byte(k))
                    return;
            if (word_reg && (next_letter || prior_letter))
                return;
            for (int k = 0; k < len; k++)
                window[k] = ASTERISK;
        endfunction

        function void push_masked(logic [CHAR_W-1:0] ch, logic last);
            masked_char_t e;
            e.ch   = ch;
            e.last = last;
            expected_masked.push_back(e);
        endfunction

        function void release_oldest(logic last);
            logic [CHAR_W-1:0] b;
            if (fill == 0)
                return;
            b = window[0];
            for (int k = 0; k < MAX_WINDOW - 1; k++)
                window[k] = window[k+1];
            fill--;
            prior_letter = is_letter(b);
            push_masked(b, last);
        endfunction

        function void take_char(logic [CHAR_W-1:0] raw, logic last);
            logic [CHAR_W-1:0] c;
            int                len;
            c = raw;
            if (raw >= UPPER_A && raw <= UPPER_Z)
                c = raw + CASE_OFFSET;
            len = active_len();
            // a lowered length pushes the excess out first, unmasked
            while (fill > len)
                release_oldest(1'b0);
            if (len == 0)
            begin
                push_masked(c, last);
                prior_letter = last ? 1'b0 : is_letter(c);
                return;
            end
            if (fill == len)
            begin
                try_mask(len, is_letter(c));
                release_oldest(1'b0);
            end
            if (fill < MAX_WINDOW)
            begin
                window[fill] = c;
                fill++;
            end
            if (last)
            begin
                try_mask(len, 1'b0);
                while (fill > 0)
                    release_oldest(fill == 1);
                prior_letter = 1'b0;
            end
        endfunction

        function void check_masked(logic [CHAR_W-1:0] ch, logic last);
            masked_char_t e;
            if (expected_masked.size() == 0)
            begin
                $display("%0t: unexpected item char_out %02h last_out %0b", $time, ch, last);
                errors++;
                return;
            end
            e = expected_masked.pop_front();
            if (ch !== e.ch)
            begin
                $display("%0t: char_out expected %02h actual %02h", $time, e.ch, ch);
                errors++;
            end
            if (last !== e.last)
            begin
                $display("%0t: last_out expected %0b actual %0b", $time, e.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_masked.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wmf_in_if  text_if ();
    wmf_out_if masked_if ();

    word_mask_filter_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text_if),
        .masked    (masked_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mask_tracker tracker = new();

    int          items_sent    = 0;
    int          burst_left    = 0;
    bit          gaps_on       = 1'b1;
    rx_pattern_t rx_mode       = RX_ALWAYS;
    int          hold_requests = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end

    // Receiver: stall on its own pattern, or hold off for a long stretch on request
    initial
    begin
        int hold_left;
        int tick;
        int holds_seen;
        hold_left       = 0;
        tick            = 0;
        holds_seen      = 0;
        masked_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_requests != holds_seen)
            begin
                hold_left  = HOLD_CYCLES;
                holds_seen = hold_requests;
            end
            if (!rst_n)
                masked_if.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                masked_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS:       masked_if.ready <= 1'b1;
                    RX_COIN:         masked_if.ready <= 1'($urandom_range(0, 1));
                    RX_EVERY_FOURTH: masked_if.ready <= (tick % 4) != 3;
                    default:         masked_if.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
        if (rst_n && masked_if.valid && masked_if.ready)
            tracker.check_masked(masked_if.char_out, masked_if.last_out);

    task automatic send_char(logic [CHAR_W-1:0] c, logic last);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            @(negedge clk);
            text_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        text_if.valid   <= 1'b1;
        text_if.char_in <= c;
        text_if.last_in <= last;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        tracker.take_char(c, last);
        items_sent++;
    endtask

    task automatic send_seq(byte_q_t seq, bit ends_text);
        foreach (seq[k])
            send_char(seq[k], ends_text && (k == seq.size() - 1));
    endtask

    // Drop valid, wait for all masked text, then let the pipeline go quiet
    task automatic settle();
        @(negedge clk);
        text_if.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_reg(idx, data);
    endtask

    task automatic load_config(int len_val, logic [PATTERN_BYTES*CHAR_W-1:0] bits, bit word);
        settle();
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len_val));
        write_reg(REG_PATTERN_LOW, bits[63:0]);
        write_reg(REG_PATTERN_HIGH, bits[127:64]);
        write_reg(REG_WORD_MODE, CFG_DATA_W'(word));
    endtask

    function automatic byte_q_t to_bytes(string s);
        byte_q_t q;
        for (int k = 0; k < s.len(); k++)
            q.push_back(s[k]);
        return q;
    endfunction

    function automatic logic [PATTERN_BYTES*CHAR_W-1:0] pattern_bits(string s);
        logic [PATTERN_BYTES*CHAR_W-1:0] bits;
        bits = '0;
        for (int k = 0; k < s.len() && k < PATTERN_BYTES; k++)
            bits[8*k +: 8] = s[k];
        return bits;
    endfunction

    function automatic logic [CHAR_W-1:0] random_letter();
        logic [CHAR_W-1:0] b;
        b = LOWER_A + CHAR_W'($urandom_range(0, 25));
        if ($urandom_range(0, 1))
            b = b - CASE_OFFSET;
        return b;
    endfunction

    // Mostly pattern copies in mixed case, near misses and separators, some noise
    function automatic byte_q_t make_text(int target, int plen,
                                          logic [PATTERN_BYTES*CHAR_W-1:0] bits);
        byte_q_t           q;
        int                r;
        int                n;
        int                idx;
        logic [CHAR_W-1:0] b;
        while (q.size() < target)
        begin
            r = $urandom_range(0, 9);
            if (r <= 3 && plen > 0)
            begin
                for (int k = 0; k < plen; k++)
                begin
                    b = bits[8*k +: 8];
                    if (b >= LOWER_A && b <= LOWER_Z && $urandom_range(0, 1))
                        b = b - CASE_OFFSET;
                    q.push_back(b);
                end
            end
            else if (r <= 5)
                q.push_back(SEPARATORS[$urandom_range(0, 9)]);
            else if (r <= 7)
            begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                begin
                    idx = (plen > 0) ? $urandom_range(0, plen - 1) : 0;
                    q.push_back(plen > 0 ? bits[8*idx +: 8] : random_letter());
                end
            end
            else if (r == 8)
                q.push_back(CHAR_W'($urandom_range(0, 255)));
            else
                q.push_back(random_letter());
        end
        return q;
    endfunction

    function automatic logic [PATTERN_BYTES*CHAR_W-1:0] random_pattern(int used);
        logic [PATTERN_BYTES*CHAR_W-1:0] bits;
        int                              r;
        for (int k = 0; k < PATTERN_BYTES; k++)
        begin
            r = $urandom_range(0, 9);
            if (k >= used)
                bits[8*k +: 8] = CHAR_W'($urandom_range(0, 255));
            else if (r <= 5)
                bits[8*k +: 8] = LOWER_A + CHAR_W'($urandom_range(0, 2));
            else if (r <= 7)
                bits[8*k +: 8] = LOWER_A + CHAR_W'($urandom_range(0, 25));
            else if (r == 8)
                bits[8*k +: 8] = ASTERISK;
            else
                bits[8*k +: 8] = CHAR_W'($urandom_range(0, 255));
        end
        return bits;
    endfunction

    task automatic run_random_phase(int phase_idx);
        int                              len_val;
        int                              r;
        int                              texts;
        int                              cut;
        logic [PATTERN_BYTES*CHAR_W-1:0] bits;
        byte_q_t                         txt;
        byte_q_t                         head;
        byte_q_t                         tail;
        r = $urandom_range(0, 19);
        if (phase_idx == 0 || r == 1)
            len_val = PATTERN_BYTES;
        else if (phase_idx == 3 || r == 2)
            len_val = 31;
        else if (phase_idx == 4 || r == 0)
            len_val = 0;
        else if (r == 3)
            len_val = $urandom_range(17, 30);
        else if (r <= 14)
            len_val = $urandom_range(1, 4);
        else
            len_val = $urandom_range(5, 15);
        bits = random_pattern(len_val > PATTERN_BYTES ? PATTERN_BYTES : len_val);
        load_config(len_val, bits, 1'($urandom_range(0, 1)));
        rx_mode = rx_pattern_t'($urandom_range(0, 3));
        gaps_on = $urandom_range(0, 3) != 0;
        if (phase_idx == 1)
        begin
            // long receiver hold with the sender flat out: the block has to back up
            gaps_on = 1'b0;
            hold_requests++;
            send_seq(make_text(40, tracker.active_len(), bits), 1'b1);
        end
        texts = $urandom_range(2, 5);
        for (int t = 0; t < texts; t++)
        begin
            if (items_sent >= TARGET_ITEMS)
                break;
            txt = make_text($urandom_range(3, 24), tracker.active_len(), bits);
            if ($urandom_range(0, 4) == 0 && txt.size() > 2)
            begin
                cut  = $urandom_range(1, txt.size() - 1);
                head = txt[0:cut-1];
                tail = txt[cut:$];
                send_seq(head, 1'b0);
                settle();
                r = $urandom_range(0, 2);
                if (r == 0)
                    write_reg(REG_PATTERN_LENGTH,
                              CFG_DATA_W'($urandom_range(0, tracker.active_len())));
                else if (r == 1)
                    write_reg(REG_WORD_MODE, CFG_DATA_W'(!tracker.word_reg));
                else
                begin
                    bits = random_pattern(PATTERN_BYTES);
                    write_reg(REG_PATTERN_LOW, bits[63:0]);
                    write_reg(REG_PATTERN_HIGH, bits[127:64]);
                end
                send_seq(tail, 1'b1);
            end
            else
                send_seq(txt, 1'b1);
        end
    endtask

    initial
    begin
        int phase_idx;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = REG_PATTERN_LENGTH;
        cfg_data        = '0;
        text_if.valid   = 1'b0;
        text_if.char_in = '0;
        text_if.last_in = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // empty pattern out of reset: bytes pass straight through
        send_seq('{8'h00, 8'hFF}, 1'b1);
        // whole word at text start, and one followed by a letter
        load_config(3, pattern_bits("cat"), 1'b1);
        send_seq(to_bytes("CAT,CATS"), 1'b1);
        // overlapping substring matches in scan order
        load_config(2, pattern_bits("aa"), 1'b0);
        send_seq(to_bytes("`AAA{"), 1'b1);
        // text shorter than the pattern
        load_config(3, pattern_bits("cat"), 1'b1);
        send_seq(to_bytes("Z"), 1'b1);
        // lower the length and swap pattern and mode in the middle of a text
        load_config(4, pattern_bits("abcd"), 1'b1);
        send_seq(to_bytes("xyz"), 1'b0);
        settle();
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(1));
        write_reg(REG_PATTERN_LOW, CFG_DATA_W'(pattern_bits("q")));
        write_reg(REG_WORD_MODE, CFG_DATA_W'(1'b0));
        send_seq(to_bytes("q"), 1'b1);

        phase_idx = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            run_random_phase(phase_idx);
            phase_idx++;
        end

        @(negedge clk);
        text_if.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
